// File: hdl/mexp_pkg.sv
// ---------------------------------------------------------------------------
// Modular exponentiation package
// Widths, microcode control word layout and the microcode program itself.
// ---------------------------------------------------------------------------
`default_nettype none

package mexp_pkg;

  // Operand width and the width of a bit counter that can hold WIDTH itself
  localparam int unsigned WIDTH = 32;
  localparam int unsigned CNT_W = $clog2(WIDTH + 1);

  // Program steps (the sequencer's program counter)
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_REDUCE,
    ST_TEST,
    ST_MUL_ACC,
    ST_SQUARE,
    ST_NEXT,
    ST_EMIT
  } step_e;

  // Jump conditions
  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_MOD_SMALL,
    COND_E_ZERO,
    COND_CNT_MORE
  } cond_e;

  // Multiplicand source for the modular multiplier
  typedef enum logic [1:0] {
    OPND_ONE,
    OPND_ACC,
    OPND_B
  } opnd_e;

  // Destination of a finished product
  typedef enum logic {
    DST_ACC,
    DST_B
  } dest_e;

  // One microcode word
  typedef struct packed {
    logic  wait_in;   // hold here until a transaction arrives
    logic  acc_zero;  // acc <= 0
    logic  acc_one;   // acc <= 1
    logic  mul_go;    // run one modular product, hold until it ends
    opnd_e mul_a;
    dest_e mul_dst;
    logic  e_shift;   // consume one exponent bit
    logic  emit;      // present acc on the output
    cond_e cond;
    step_e target;
  } ctrl_t;

  // Sequencer to datapath
  typedef struct packed {
    ctrl_t cw;
    logic  step_done;  // current step completes this cycle
    logic  mul_start;  // pulse to launch the multiplier
  } seq_ctl_t;

  // Datapath to sequencer
  typedef struct packed {
    logic in_valid;
    logic mod_small;
    logic e_lsb;
    logic cnt_more;
    logic mul_done;
    logic out_full;
  } seq_stat_t;

  // Microcode ROM
  function automatic ctrl_t ucode(step_e s);
    ctrl_t w;
    w = '0;
    unique case (s)
      ST_IDLE: begin
        w.wait_in = 1'b1;
        w.cond    = COND_NEVER;
      end
      ST_CHECK: begin
        w.acc_zero = 1'b1;
        w.cond     = COND_MOD_SMALL;
        w.target   = ST_EMIT;
      end
      ST_REDUCE: begin
        // 1 * base mod n leaves the reduced base
        w.acc_one = 1'b1;
        w.mul_go  = 1'b1;
        w.mul_a   = OPND_ONE;
        w.mul_dst = DST_B;
      end
      ST_TEST: begin
        w.cond   = COND_E_ZERO;
        w.target = ST_SQUARE;
      end
      ST_MUL_ACC: begin
        w.mul_go  = 1'b1;
        w.mul_a   = OPND_ACC;
        w.mul_dst = DST_ACC;
      end
      ST_SQUARE: begin
        w.mul_go  = 1'b1;
        w.mul_a   = OPND_B;
        w.mul_dst = DST_B;
      end
      ST_NEXT: begin
        w.e_shift = 1'b1;
        w.cond    = COND_CNT_MORE;
        w.target  = ST_TEST;
      end
      ST_EMIT: begin
        w.emit   = 1'b1;
        w.cond   = COND_ALWAYS;
        w.target = ST_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// File: hdl/modular_exponentiation.sv
// When the modulus is below 2 no product is run; otherwise the bit-serial
// multiplier runs once or twice per exponent bit. One transaction at a time;
// the next is taken once the result has been written to the output register.
// Reset: asynchronous, active low; modulus returns to 2, sequencer to idle.
// ---------------------------------------------------------------------------
// Modular exponentiation top level
// Right-to-left square-and-multiply under microcode control.
// ---------------------------------------------------------------------------
`default_nettype none

module modular_exponentiation (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       modulus_we_i,
  input  wire logic [mexp_pkg::WIDTH-1:0] modulus_i,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire logic [mexp_pkg::WIDTH-1:0] base_value_i,
  input  wire logic [mexp_pkg::WIDTH-1:0] exponent_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic [mexp_pkg::WIDTH-1:0]      power_result_o
);
  import mexp_pkg::*;

  seq_ctl_t         ctl;
  seq_stat_t        stat;

  logic [WIDTH-1:0] modulus_q;
  logic [WIDTH-1:0] acc_q;
  logic [WIDTH-1:0] b_q;
  logic [WIDTH-1:0] e_q;
  logic [CNT_W-1:0] cnt_q;
  logic             out_valid_q;
  logic [WIDTH-1:0] result_q;

  logic             accept;
  logic             out_full;
  logic [WIDTH-1:0] mul_a;
  logic             mul_done;
  logic [WIDTH-1:0] mul_res;

  assign accept   = in_valid_i && ctl.cw.wait_in;
  assign out_full = out_valid_q && out_stall_i;

  // Status back to the sequencer
  always_comb begin
    stat.in_valid  = in_valid_i;
    stat.mod_small = (modulus_q < WIDTH'(2));
    stat.e_lsb     = e_q[0];
    stat.cnt_more  = (cnt_q != CNT_W'(1));
    stat.mul_done  = mul_done;
    stat.out_full  = out_full;
  end

  // Multiplicand select
  always_comb begin
    unique case (ctl.cw.mul_a)
      OPND_ONE: mul_a = WIDTH'(1);
      OPND_ACC: mul_a = acc_q;
      OPND_B:   mul_a = b_q;
      default:  mul_a = '0;
    endcase
  end

  mexp_useq u_useq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctl_o  (ctl)
  );

  mexp_mulmod u_mulmod (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (ctl.mul_start),
    .a_i      (mul_a),
    .b_i      (b_q),
    .m_i      (modulus_q),
    .done_o   (mul_done),
    .result_o (mul_res)
  );

  // Control registers: modulus, bit counter, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q   <= WIDTH'(2);
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (modulus_we_i) begin
        modulus_q <= modulus_i;
      end
      if (accept) begin
        cnt_q <= CNT_W'(WIDTH);
      end else if (ctl.cw.e_shift && ctl.step_done) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
      if (ctl.cw.emit && !out_full) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      b_q <= base_value_i;
      e_q <= exponent_i;
    end else begin
      if (mul_done && ctl.cw.mul_dst == DST_B) begin
        b_q <= mul_res;
      end
      if (ctl.cw.e_shift && ctl.step_done) begin
        e_q <= {1'b0, e_q[WIDTH-1:1]};
      end
    end
    if (ctl.cw.acc_zero) begin
      acc_q <= '0;
    end else if (ctl.cw.acc_one) begin
      acc_q <= WIDTH'(1);
    end else if (mul_done && ctl.cw.mul_dst == DST_ACC) begin
      acc_q <= mul_res;
    end
    if (ctl.cw.emit && !out_full) begin
      result_q <= acc_q;
    end
  end

  assign in_stall_o     = !ctl.cw.wait_in;
  assign out_valid_o    = out_valid_q;
  assign power_result_o = result_q;

endmodule

`default_nettype wire

// File: hdl/mexp_mulmod.sv
// ---------------------------------------------------------------------------
// Bit-serial modular multiplier
// Double-and-add over the multiplier bits, MSB first, one bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module mexp_mulmod (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic [mexp_pkg::WIDTH-1:0] a_i,
  input  wire logic [mexp_pkg::WIDTH-1:0] b_i,
  input  wire logic [mexp_pkg::WIDTH-1:0] m_i,
  output logic                            done_o,
  output logic [mexp_pkg::WIDTH-1:0]      result_o
);
  import mexp_pkg::*;

  logic [WIDTH-1:0] r_q, r_d;
  logic [WIDTH-1:0] a_q;
  logic [WIDTH-1:0] b_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic             done_q;

  logic [WIDTH:0]   m_ext;
  logic [WIDTH:0]   dbl;
  logic [WIDTH:0]   dbl_red;
  logic [WIDTH:0]   sum;
  logic [WIDTH:0]   sum_red;

  // One step: r = 2r mod m, then r = r + a mod m when the bit is set
  always_comb begin
    m_ext   = {1'b0, m_i};
    dbl     = {r_q, 1'b0};
    dbl_red = (dbl >= m_ext) ? (dbl - m_ext) : dbl;
    sum     = {1'b0, dbl_red[WIDTH-1:0]} + {1'b0, a_q};
    sum_red = (sum >= m_ext) ? (sum - m_ext) : sum;
    r_d     = b_q[WIDTH-1] ? sum_red[WIDTH-1:0] : dbl_red[WIDTH-1:0];
  end

  // Control: busy flag, bit counter, completion pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(WIDTH);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Operands and running remainder
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      r_q <= '0;
      a_q <= a_i;
      b_q <= b_i;
    end else if (busy_q) begin
      r_q <= r_d;
      b_q <= {b_q[WIDTH-2:0], 1'b0};
    end
  end

  assign done_o   = done_q;
  assign result_o = r_q;

endmodule

`default_nettype wire

// File: hdl/mexp_useq.sv
// ---------------------------------------------------------------------------
// Microcode sequencer
// Program counter over the microcode ROM with holds and conditional jumps.
// ---------------------------------------------------------------------------
`default_nettype none

module mexp_useq (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire mexp_pkg::seq_stat_t stat_i,
  output mexp_pkg::seq_ctl_t       ctl_o
);
  import mexp_pkg::*;

  step_e pc_q, pc_d;
  logic  wait_q, wait_d;
  ctrl_t cw;
  logic  hold;
  logic  jump;

  // Fetch, hold and jump decision
  always_comb begin
    cw   = ucode(pc_q);
    hold = (cw.wait_in && !stat_i.in_valid)
        || (cw.mul_go && !stat_i.mul_done)
        || (cw.emit && stat_i.out_full);

    unique case (cw.cond)
      COND_NEVER:     jump = 1'b0;
      COND_ALWAYS:    jump = 1'b1;
      COND_MOD_SMALL: jump = stat_i.mod_small;
      COND_E_ZERO:    jump = !stat_i.e_lsb;
      COND_CNT_MORE:  jump = stat_i.cnt_more;
      default:        jump = 1'b0;
    endcase

    pc_d = pc_q;
    if (!hold) begin
      pc_d = jump ? cw.target : step_e'(pc_q + 3'd1);
    end

    // Multiplier launched once on entry to a multiply step
    wait_d = wait_q;
    if (cw.mul_go && !wait_q) begin
      wait_d = 1'b1;
    end else if (stat_i.mul_done) begin
      wait_d = 1'b0;
    end

    ctl_o.cw        = cw;
    ctl_o.step_done = !hold;
    ctl_o.mul_start = cw.mul_go && !wait_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q   <= ST_IDLE;
      wait_q <= 1'b0;
    end else begin
      pc_q   <= pc_d;
      wait_q <= wait_d;
    end
  end

endmodule

`default_nettype wire
